// ===== design/dsf_pkg.sv =====
package dsf_pkg;

    localparam int INDEX_DIGITS = 8;
    localparam int DIG_W        = (INDEX_DIGITS > 1) ? $clog2(INDEX_DIGITS) : 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_PAYLOAD_BYTES = 2'd0;
    localparam cfg_index_t CFG_LEAD_BASES    = 2'd1;
    localparam cfg_index_t CFG_TAIL_BASES    = 2'd2;

    localparam logic [7:0] PAYLOAD_BYTES_RST = 8'd25;
    localparam logic [7:0] LEAD_BASES_RST    = 8'd57;
    localparam logic [7:0] TAIL_BASES_RST    = 8'd147;

    typedef logic [1:0] section_t;
    localparam section_t SEC_LEFT    = 2'd0;
    localparam section_t SEC_INDEX   = 2'd1;
    localparam section_t SEC_PAYLOAD = 2'd2;
    localparam section_t SEC_RIGHT   = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } byte_beat_t;

    typedef struct packed {
        logic [1:0] base;
        section_t   section;
        logic       strand_end;
        logic       last;
    } base_beat_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        open_strand;
        logic        close_strand;
        logic [7:0]  lead_bases;
        logic [7:0]  tail_bases;
        logic [15:0] strand_index;
    } frame_cmd_t;

endpackage

// ===== design/dna_strand_framer.sv =====
// a byte is queued and loaded into the command register before its first base is registered
// throughput: one base per cycle while base_ready is high and a byte waits, 4 bases per byte,
// plus 4 + 8 for the primer and index of an opening byte and 4 for a closing primer
// a 2-entry command queue lets the byte side run ahead of the base side
// reset: async active low, clears index, strand count, queue and output valid,
// and loads the default payload limit and primers
module dna_strand_framer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  dsf_pkg::cfg_index_t cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  dsf_pkg::byte_beat_t byte_beat,
    output logic                base_valid,
    input  logic                base_ready,
    output dsf_pkg::base_beat_t base_beat
);
    import dsf_pkg::*;

    logic       push;
    frame_cmd_t push_cmd;
    logic       queue_full;
    logic       pop;
    logic       pop_valid;
    frame_cmd_t pop_cmd;

    dsf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_beat  (byte_beat),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    dsf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd)
    );

    dsf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (pop_valid),
        .cmd        (pop_cmd),
        .pop        (pop),
        .base_valid (base_valid),
        .base_ready (base_ready),
        .base_beat  (base_beat)
    );

endmodule

// ===== design/dsf_front.sv =====
module dsf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  dsf_pkg::cfg_index_t cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  dsf_pkg::byte_beat_t byte_beat,
    input  logic               queue_full,
    output logic               push,
    output dsf_pkg::frame_cmd_t push_cmd
);
    import dsf_pkg::*;

    logic [7:0]  payload_bytes_reg;
    logic [7:0]  lead_bases_reg;
    logic [7:0]  tail_bases_reg;
    logic [15:0] strand_index_reg;
    logic [7:0]  bytes_in_strand_reg;

    logic [7:0] limit;
    logic [7:0] count_inc;
    logic       close_strand;

    assign byte_ready   = !queue_full;
    assign push         = byte_valid && !queue_full;
    assign limit        = (payload_bytes_reg == 8'd0) ? 8'd1 : payload_bytes_reg;
    assign count_inc    = bytes_in_strand_reg + 8'd1;
    assign close_strand = byte_beat.end_of_file || (count_inc >= limit) || (count_inc == 8'd0);

    always_comb
    begin
        push_cmd.data_byte    = byte_beat.data_byte;
        push_cmd.open_strand  = (bytes_in_strand_reg == 8'd0);
        push_cmd.close_strand = close_strand;
        push_cmd.lead_bases   = lead_bases_reg;
        push_cmd.tail_bases   = tail_bases_reg;
        push_cmd.strand_index = strand_index_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_bytes_reg   <= PAYLOAD_BYTES_RST;
            lead_bases_reg      <= LEAD_BASES_RST;
            tail_bases_reg      <= TAIL_BASES_RST;
            strand_index_reg    <= '0;
            bytes_in_strand_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PAYLOAD_BYTES: payload_bytes_reg <= cfg_data;
                    CFG_LEAD_BASES:    lead_bases_reg    <= cfg_data;
                    CFG_TAIL_BASES:    tail_bases_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (push)
            begin
                if (close_strand)
                begin
                    bytes_in_strand_reg <= '0;
                    strand_index_reg    <= strand_index_reg + 16'd1;
                end
                else
                begin
                    bytes_in_strand_reg <= count_inc;
                end
            end
        end
    end

endmodule

// ===== design/dsf_queue.sv =====
module dsf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dsf_pkg::frame_cmd_t push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                pop_valid,
    output dsf_pkg::frame_cmd_t pop_cmd
);
    import dsf_pkg::*;

    frame_cmd_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = mem[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/dsf_back.sv =====
module dsf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  dsf_pkg::frame_cmd_t cmd,
    output logic                pop,
    output logic                base_valid,
    input  logic                base_ready,
    output dsf_pkg::base_beat_t base_beat
);
    import dsf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEFT,
        ST_INDEX,
        ST_PAYLOAD,
        ST_RIGHT
    } state_t;

    state_t           state_reg, state_next;
    frame_cmd_t       cmd_reg, cmd_next;
    logic [1:0]       pos_reg, pos_next;
    logic [DIG_W-1:0] dig_reg, dig_next;
    logic             out_valid_reg;
    base_beat_t       out_beat_reg;

    logic             emit;
    logic             finishing;
    base_beat_t       cur;
    logic [1:0]       shift_pos;

    assign base_valid = out_valid_reg;
    assign base_beat  = out_beat_reg;
    assign emit       = (state_reg != ST_IDLE) && (!out_valid_reg || base_ready);
    assign shift_pos  = 2'd3 - pos_reg;

    always_comb
    begin
        cur       = '0;
        finishing = 1'b0;
        unique case (state_reg)
            ST_LEFT:
            begin
                cur.base    = 2'(cmd_reg.lead_bases >> {shift_pos, 1'b0});
                cur.section = SEC_LEFT;
            end
            ST_INDEX:
            begin
                cur.base    = 2'(cmd_reg.strand_index >> {dig_reg, 1'b0});
                cur.section = SEC_INDEX;
            end
            ST_PAYLOAD:
            begin
                cur.base    = 2'(cmd_reg.data_byte >> {shift_pos, 1'b0});
                cur.section = SEC_PAYLOAD;
                finishing   = (pos_reg == 2'd3) && !cmd_reg.close_strand;
                cur.last    = finishing;
            end
            ST_RIGHT:
            begin
                cur.base       = 2'(cmd_reg.tail_bases >> {shift_pos, 1'b0});
                cur.section    = SEC_RIGHT;
                finishing      = (pos_reg == 2'd3);
                cur.strand_end = finishing;
                cur.last       = finishing;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        dig_next   = dig_reg;
        pop        = 1'b0;
        if ((state_reg == ST_IDLE) || (emit && finishing))
        begin
            pos_next = 2'd0;
            if (cmd_valid)
            begin
                pop        = 1'b1;
                cmd_next   = cmd;
                state_next = cmd.open_strand ? ST_LEFT : ST_PAYLOAD;
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end
        else if (emit)
        begin
            unique case (state_reg)
                ST_LEFT:
                begin
                    pos_next = pos_reg + 2'd1;
                    if (pos_reg == 2'd3)
                    begin
                        state_next = ST_INDEX;
                        dig_next   = DIG_W'(INDEX_DIGITS - 1);
                    end
                end
                ST_INDEX:
                begin
                    dig_next = dig_reg - 1'b1;
                    if (dig_reg == '0)
                    begin
                        state_next = ST_PAYLOAD;
                        pos_next   = 2'd0;
                    end
                end
                ST_PAYLOAD:
                begin
                    pos_next = pos_reg + 2'd1;
                    if (pos_reg == 2'd3)
                    begin
                        state_next = ST_RIGHT;
                    end
                end
                ST_RIGHT:
                begin
                    pos_next = pos_reg + 2'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            dig_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            dig_reg   <= dig_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (base_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (emit)
        begin
            out_beat_reg <= cur;
        end
    end

endmodule
